/* sv/amsd_pkg.sv */
`default_nettype none
package amsd_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int SAMPLE_BYTES = 3;
  localparam int SAMPLE_W     = 24;
  localparam int CH_W         = 2;
  localparam int BYTE_W       = $clog2(SAMPLE_BYTES + 1);
  localparam int MASK_W       = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [MASK_W-1:0]   MASK_RESET   = MASK_W'(15);
  localparam logic [SAMPLE_W-1:0] PERIOD_RESET = SAMPLE_W'(500);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_MASK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = CFG_IDX_W'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // one classified conversion, handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]                         next_mux;
    logic [CH_W-1:0]                         channel;
    logic [SAMPLE_W-1:0]                     value;
    logic                                    emit;
    logic [MASK_W-1:0]                       mask;
    logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0]   samples;
  } job_t;

  function automatic logic [7:0] byte_of(input logic [SAMPLE_W-1:0] sample,
                                         input logic [BYTE_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(sample) >> {idx, 3'b000};
    return wide[7:0];
  endfunction

endpackage
`default_nettype wire

/* sv/amsd_front.sv */
`default_nettype none
module amsd_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [amsd_pkg::SAMPLE_W-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        rx_byte_low,
  input  wire logic [7:0]                        rx_byte_mid,
  input  wire logic [7:0]                        rx_byte_high,
  input  wire logic                              queue_has_room,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output amsd_pkg::job_t                         q_data
);

  logic [amsd_pkg::MASK_W-1:0]   signal_mask;
  logic [amsd_pkg::SAMPLE_W-1:0] sample_period;
  logic [amsd_pkg::CH_W-1:0]     current_channel;
  logic [amsd_pkg::SAMPLE_W-1:0] scan_count;
  logic [amsd_pkg::NUM_CHANNELS-1:0][amsd_pkg::SAMPLE_W-1:0] channel_samples;

  logic [amsd_pkg::SAMPLE_W-1:0] value;
  logic [amsd_pkg::SAMPLE_W-1:0] count_inc;
  logic [amsd_pkg::SAMPLE_W-1:0] scan_count_next;
  logic [amsd_pkg::CH_W-1:0]     nmux;
  logic [amsd_pkg::NUM_CHANNELS-1:0][amsd_pkg::SAMPLE_W-1:0] samples_next;
  logic                          scan_done;
  logic                          reached;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    value     = {rx_byte_high, rx_byte_mid, rx_byte_low};
    scan_done = current_channel == amsd_pkg::CH_W'(amsd_pkg::NUM_CHANNELS - 1);
    nmux      = scan_done ? '0 : current_channel + amsd_pkg::CH_W'(1);
    count_inc = scan_count + amsd_pkg::SAMPLE_W'(1);
    reached   = count_inc >= sample_period;
    scan_count_next = scan_count;
    if (scan_done) begin
      scan_count_next = reached ? count_inc - sample_period : count_inc;
    end
    samples_next = channel_samples;
    samples_next[current_channel] = value;

    q_data.next_mux = nmux;
    q_data.channel  = current_channel;
    q_data.value    = value;
    q_data.emit     = scan_done && reached && queue_has_room && (signal_mask != '0);
    q_data.mask     = signal_mask;
    q_data.samples  = samples_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_mask     <= amsd_pkg::MASK_RESET;
      sample_period   <= amsd_pkg::PERIOD_RESET;
      current_channel <= '0;
      scan_count      <= '0;
      channel_samples <= '1;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == amsd_pkg::REG_SIGNAL_MASK) begin
          signal_mask <= cfg_data[amsd_pkg::MASK_W-1:0];
        end else if (cfg_index == amsd_pkg::REG_SAMPLE_PERIOD) begin
          sample_period <= cfg_data;
        end
      end
      if (q_push) begin
        current_channel <= nmux;
        scan_count      <= scan_count_next;
        channel_samples <= samples_next;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/amsd_queue.sv */
`default_nettype none
module amsd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire amsd_pkg::job_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output amsd_pkg::job_t      head
);

  amsd_pkg::job_t                entries [amsd_pkg::QUEUE_DEPTH];
  logic [amsd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [amsd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [amsd_pkg::QCNT_W-1:0]   fill;

  assign full  = fill == amsd_pkg::QCNT_W'(amsd_pkg::QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + amsd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + amsd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + amsd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - amsd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/amsd_back.sv */
`default_nettype none
module amsd_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_empty,
  input  wire amsd_pkg::job_t                  q_head,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [amsd_pkg::CH_W-1:0]            next_mux,
  output logic [amsd_pkg::CH_W-1:0]            sampled_channel,
  output logic [amsd_pkg::SAMPLE_W-1:0]        sample_value,
  output logic [7:0]                           out_byte,
  output logic                                 out_byte_valid,
  output logic                                 last
);

  amsd_pkg::job_t               job;
  logic                         busy;
  logic [amsd_pkg::CH_W-1:0]    cur_ch;
  logic [amsd_pkg::BYTE_W-1:0]  cur_byte;

  logic                         advance;
  logic [amsd_pkg::CH_W-1:0]    first_ch;
  logic [amsd_pkg::CH_W-1:0]    next_ch;
  logic                         next_found;
  logic                         byte_last;
  logic                         final_result;

  assign advance = !out_valid || !out_stall;
  assign q_pop   = !busy && !q_empty;

  // lowest masked channel of the incoming job, next masked channel above cursor
  always_comb begin
    first_ch   = '0;
    next_ch    = '0;
    next_found = 1'b0;
    for (int c = amsd_pkg::NUM_CHANNELS - 1; c >= 0; c--) begin
      if (q_head.mask[c]) begin
        first_ch = amsd_pkg::CH_W'(c);
      end
      if (job.mask[c] && (amsd_pkg::CH_W'(c) > cur_ch)) begin
        next_ch    = amsd_pkg::CH_W'(c);
        next_found = 1'b1;
      end
    end
    byte_last    = cur_byte == amsd_pkg::BYTE_W'(amsd_pkg::SAMPLE_BYTES - 1);
    final_result = !job.emit || (byte_last && !next_found);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job      <= q_head;
      cur_ch   <= first_ch;
      cur_byte <= '0;
    end else if (busy && advance && !final_result) begin
      if (byte_last) begin
        cur_ch   <= next_ch;
        cur_byte <= '0;
      end else begin
        cur_byte <= cur_byte + amsd_pkg::BYTE_W'(1);
      end
    end
    if (busy && advance) begin
      next_mux        <= job.next_mux;
      sampled_channel <= job.channel;
      sample_value    <= job.value;
      out_byte        <= job.emit ? amsd_pkg::byte_of(job.samples[cur_ch], cur_byte) : 8'h00;
      out_byte_valid  <= job.emit;
      last            <= final_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (busy && advance && final_result) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= busy;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/adc_mux_scan_decimator.sv */
// Four-channel multiplexed ADC scanner with decimated byte output.
// Input channel (in_valid / in_stall): one request per finished conversion of
// the selected channel: three bytes plus the queue_has_room flag.
// Output channel (out_valid / out_stall): each request gives either one
// result with out_byte_valid low, or one result per queued sample byte
// (low byte first, lowest masked channel first); last marks the final one.
// next_mux, sampled_channel and sample_value repeat on every result.
// Config port (cfg_valid / cfg_ready, always ready): index 0 signal_mask,
// index 1 sample_period; other indexes ignored. Write only while idle.
// A request passes through the job queue write, then the job load in the back
// stage, before it reaches the output register. The back stage loads a job
// and then gives one result per cycle while the output is not stalled; it
// takes the next job only after the last result of the current one; the
// front keeps accepting until the two-deep queue fills.
// Reset clears the channel pointer and scan count, sets all stored samples
// to all ones and restores mask 15 / period 500. A stalled output holds its
// result; the back stage then freezes and the queue backs up onto in_stall.
`default_nettype none
module adc_mux_scan_decimator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [amsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [amsd_pkg::SAMPLE_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    rx_byte_low,
  input  wire logic [7:0]                    rx_byte_mid,
  input  wire logic [7:0]                    rx_byte_high,
  input  wire logic                          queue_has_room,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [amsd_pkg::CH_W-1:0]          next_mux,
  output logic [amsd_pkg::CH_W-1:0]          sampled_channel,
  output logic [amsd_pkg::SAMPLE_W-1:0]      sample_value,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               last
);

  amsd_pkg::job_t push_job;
  amsd_pkg::job_t head_job;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // front: config registers, channel rotation, sample store, decimation
  amsd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte_low    (rx_byte_low),
    .rx_byte_mid    (rx_byte_mid),
    .rx_byte_high   (rx_byte_high),
    .queue_has_room (queue_has_room),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (push_job)
  );

  // jobs carry a snapshot of the samples, so later conversions can't corrupt them
  amsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head_job)
  );

  // back: serialises each job into results, one per cycle while the output is not stalled
  amsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_head          (head_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .next_mux        (next_mux),
    .sampled_channel (sampled_channel),
    .sample_value    (sample_value),
    .out_byte        (out_byte),
    .out_byte_valid  (out_byte_valid),
    .last            (last)
  );

endmodule
`default_nettype wire
